### sv/nrcc_pkg.sv
// Shared widths, item structs and the reference colour table of the colour classifier.
package nrcc_pkg;

  localparam int unsigned ChanW    = 16;  // raw channel count
  localparam int unsigned ScaledW  = 8;   // scaled channel
  localparam int unsigned ProdW    = ChanW + ScaledW;  // clamped count times 255
  localparam int unsigned QuoBits  = ScaledW;          // one division cell per quotient bit
  localparam int unsigned ShiftW   = $clog2(QuoBits);
  localparam int unsigned IdxW     = 4;
  localparam int unsigned DistW    = 18;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned NumRefs  = 9;
  localparam int unsigned InDataW  = 48;  // 3 x 16 bits
  localparam int unsigned OutDataW = 48;  // 46 bits used, padded to whole bytes

  // Start value of the running minimum; above any reachable distance.
  localparam logic [DistW-1:0] DistMax = '1;

  localparam logic [ScaledW-1:0] RefRgb [NumRefs][NumChan] = '{
    '{8'd65,  8'd30,  8'd24},
    '{8'd85,  8'd27,  8'd18},
    '{8'd57,  8'd34,  8'd15},
    '{8'd21,  8'd26,  8'd21},
    '{8'd100, 8'd20,  8'd20},
    '{8'd20,  8'd100, 8'd20},
    '{8'd220, 8'd220, 8'd220},
    '{8'd80,  8'd80,  8'd80},
    '{8'd15,  8'd15,  8'd15}
  };

  // Item travelling through the division cells.
  typedef struct packed {
    logic [NumChan-1:0][ProdW-1:0]   rem;
    logic [NumChan-1:0][ScaledW-1:0] quo;
  } div_t;

  // Item travelling through the distance cells.
  typedef struct packed {
    logic [NumChan-1:0][ScaledW-1:0] rgb;
    logic [IdxW-1:0]                 idx;
    logic [DistW-1:0]                min_dist;
  } dist_t;

endpackage

### sv/nrcc_div_cell.sv
// One restoring division cell: settles one quotient bit for all three channels.
module nrcc_div_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [nrcc_pkg::ChanW-1:0]   divisor_i,
  input  logic [nrcc_pkg::ShiftW-1:0]  shift_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  nrcc_pkg::div_t               data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output nrcc_pkg::div_t               data_o
);

  logic                          valid_q;
  nrcc_pkg::div_t                data_q, data_d;
  logic [nrcc_pkg::ProdW-1:0]    div_sh;

  assign div_sh  = nrcc_pkg::ProdW'(divisor_i) << shift_i;
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = data_i;
    for (int c = 0; c < nrcc_pkg::NumChan; c++) begin
      if (data_i.rem[c] >= div_sh) begin
        data_d.rem[c] = data_i.rem[c] - div_sh;
        data_d.quo[c] = {data_i.quo[c][nrcc_pkg::ScaledW-2:0], 1'b1};
      end else begin
        data_d.quo[c] = {data_i.quo[c][nrcc_pkg::ScaledW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/nrcc_dist_cell.sv
// One distance cell: measures against its reference colour and keeps the running minimum.
module nrcc_dist_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [nrcc_pkg::IdxW-1:0]   ref_idx_i,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  nrcc_pkg::dist_t             data_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output nrcc_pkg::dist_t             data_o
);

  logic                            valid_q;
  nrcc_pkg::dist_t                 data_q, data_d;
  logic [nrcc_pkg::ScaledW-1:0]    diff [nrcc_pkg::NumChan];
  logic [2*nrcc_pkg::ScaledW-1:0]  sq   [nrcc_pkg::NumChan];
  logic [nrcc_pkg::DistW-1:0]      cur_dist;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    cur_dist = '0;
    for (int c = 0; c < nrcc_pkg::NumChan; c++) begin
      diff[c] = (data_i.rgb[c] >= nrcc_pkg::RefRgb[ref_idx_i][c])
              ? data_i.rgb[c] - nrcc_pkg::RefRgb[ref_idx_i][c]
              : nrcc_pkg::RefRgb[ref_idx_i][c] - data_i.rgb[c];
      sq[c]    = diff[c] * diff[c];
      cur_dist = cur_dist + nrcc_pkg::DistW'(sq[c]);
    end
    data_d = data_i;
    // strict compare keeps the earliest reference on a tie
    if (cur_dist < data_i.min_dist) begin
      data_d.idx      = ref_idx_i;
      data_d.min_dist = cur_dist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/nearest_reference_color_classifier.sv
// Top level of the nearest reference colour classifier.
// Takes one item per cycle unless a stage is stalled, and delivers one result per item, in
// order: a front stage clamps each channel to full_scale and multiplies by 255, eight
// division cells each settle one bit of the scaled value, and nine distance cells each
// compare against one reference colour, the last of them holding the result on the master
// side. Every stage stalls on its own, so bubbles close up while the output is held.
// full_scale is used live by the division cells; the user must write it only with the
// pipeline empty (not enforced by the block); a full_scale of zero gives scaled channels of zero.
module nearest_reference_color_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nrcc_pkg::ChanW-1:0]     cfg_wdata_i,    // full_scale
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // red_raw[15:0], green_raw[31:16], blue_raw[47:32]
  input  logic [nrcc_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // red_scaled[7:0], green_scaled[15:8], blue_scaled[23:16], color_index[27:24],
  // best_distance[45:28], zero[47:46]
  output logic [nrcc_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic [nrcc_pkg::ChanW-1:0] full_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= '1;
    end else if (cfg_we_i) begin
      full_scale_q <= cfg_wdata_i;
    end
  end

  // Front stage: clamp and multiply by 255
  logic                     front_valid_q;
  logic                     front_ready;
  nrcc_pkg::div_t           front_q, front_d;
  logic [nrcc_pkg::ChanW-1:0] clamped [nrcc_pkg::NumChan];

  always_comb begin
    for (int c = 0; c < nrcc_pkg::NumChan; c++) begin
      clamped[c] = s_axis_tdata[c*nrcc_pkg::ChanW +: nrcc_pkg::ChanW];
      if (clamped[c] > full_scale_q) begin
        clamped[c] = full_scale_q;
      end
      front_d.rem[c] = {clamped[c], {nrcc_pkg::ScaledW{1'b0}}}
                     - nrcc_pkg::ProdW'(clamped[c]);
      front_d.quo[c] = '0;
    end
  end

  logic [nrcc_pkg::QuoBits:0] div_valid;
  logic [nrcc_pkg::QuoBits:0] div_ready;
  nrcc_pkg::div_t             div_data [nrcc_pkg::QuoBits+1];

  assign s_axis_tready = !front_valid_q || front_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      front_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      front_q <= front_d;
    end
  end

  assign div_valid[0] = front_valid_q;
  assign div_data[0]  = front_q;
  assign front_ready  = div_ready[0];

  // Division chain, most significant quotient bit first
  for (genvar k = 0; k < nrcc_pkg::QuoBits; k++) begin : g_div
    nrcc_div_cell u_div_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (full_scale_q),
      .shift_i   (nrcc_pkg::ShiftW'(nrcc_pkg::QuoBits - 1 - k)),
      .valid_i   (div_valid[k]),
      .ready_o   (div_ready[k]),
      .data_i    (div_data[k]),
      .valid_o   (div_valid[k+1]),
      .ready_i   (div_ready[k+1]),
      .data_o    (div_data[k+1])
    );
  end

  // Hand over to the distance chain
  logic [nrcc_pkg::NumRefs:0] dist_valid;
  logic [nrcc_pkg::NumRefs:0] dist_ready;
  nrcc_pkg::dist_t            dist_data [nrcc_pkg::NumRefs+1];

  always_comb begin
    for (int c = 0; c < nrcc_pkg::NumChan; c++) begin
      // zero full scale: drop the quotient
      dist_data[0].rgb[c] = (full_scale_q == '0) ? '0 : div_data[nrcc_pkg::QuoBits].quo[c];
    end
    dist_data[0].idx      = '0;
    dist_data[0].min_dist = nrcc_pkg::DistMax;
  end

  assign dist_valid[0]                = div_valid[nrcc_pkg::QuoBits];
  assign div_ready[nrcc_pkg::QuoBits] = dist_ready[0];

  for (genvar r = 0; r < nrcc_pkg::NumRefs; r++) begin : g_dist
    nrcc_dist_cell u_dist_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ref_idx_i (nrcc_pkg::IdxW'(r)),
      .valid_i   (dist_valid[r]),
      .ready_o   (dist_ready[r]),
      .data_i    (dist_data[r]),
      .valid_o   (dist_valid[r+1]),
      .ready_i   (dist_ready[r+1]),
      .data_o    (dist_data[r+1])
    );
  end

  assign m_axis_tvalid                  = dist_valid[nrcc_pkg::NumRefs];
  assign dist_ready[nrcc_pkg::NumRefs]  = m_axis_tready;
  assign m_axis_tdata = {2'b00,
                         dist_data[nrcc_pkg::NumRefs].min_dist,
                         dist_data[nrcc_pkg::NumRefs].idx,
                         dist_data[nrcc_pkg::NumRefs].rgb};

endmodule

### tb/sv/nearest_reference_color_classifier_test.sv
// Self-checking stream testbench for the nearest reference colour classifier.
module nearest_reference_color_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumColours = 9;
  localparam int unsigned DrainWait  = 24;  // pipeline latency plus margin

  // Reference colours in table order: red, green, blue.
  localparam logic [7:0] RefColour [NumColours][3] = '{
    '{8'd65,  8'd30,  8'd24},
    '{8'd85,  8'd27,  8'd18},
    '{8'd57,  8'd34,  8'd15},
    '{8'd21,  8'd26,  8'd21},
    '{8'd100, 8'd20,  8'd20},
    '{8'd20,  8'd100, 8'd20},
    '{8'd220, 8'd220, 8'd220},
    '{8'd80,  8'd80,  8'd80},
    '{8'd15,  8'd15,  8'd15}
  };

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } pixel_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic [17:0] best_dist;
    logic [3:0]  idx;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } class_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_we_i      = 1'b0;
  logic [nrcc_pkg::ChanW-1:0]     cfg_wdata_i   = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [nrcc_pkg::InDataW-1:0]   s_axis_tdata  = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [nrcc_pkg::OutDataW-1:0]  m_axis_tdata;

  pixel_t      pixel_q [$];
  class_t      class_q [$];
  logic [15:0] model_fs = 16'hFFFF;
  int unsigned mismatches = 0;
  logic        pixel_taken = 1'b0;
  bit          calm = 1'b0;
  bit          long_hold_due = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  nearest_reference_color_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Clamp, scale to eight bits and pick the nearest reference, first minimum wins.
  function automatic class_t nearest_colour(input logic [15:0] r, g, b, fs);
    class_t      res;
    logic [15:0] raw [3];
    logic [7:0]  ch [3];
    int unsigned clamped;
    int unsigned diff;
    int unsigned d;
    int unsigned best_d;
    raw = '{r, g, b};
    res = '0;
    best_d = 0;
    for (int c = 0; c < 3; c++) begin
      clamped = (raw[c] > fs) ? fs : raw[c];
      ch[c] = (fs == 16'd0) ? 8'd0 : 8'((clamped * 255) / fs);
    end
    for (int k = 0; k < NumColours; k++) begin
      d = 0;
      for (int c = 0; c < 3; c++) begin
        diff = (ch[c] >= RefColour[k][c]) ? ch[c] - RefColour[k][c] : RefColour[k][c] - ch[c];
        d += diff * diff;
      end
      if (k == 0 || d < best_d) begin
        best_d = d;
        res.idx = 4'(k);
      end
    end
    res.red = ch[0];
    res.green = ch[1];
    res.blue = ch[2];
    res.best_dist = 18'(best_d);
    return res;
  endfunction

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Sender: hold an item until taken, then advance or idle for a burst.
  always @(negedge clk_i) begin
    pixel_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || pixel_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 14) - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        nxt = pixel_q.pop_front();
        s_axis_tdata <= nxt;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to back the pipeline up.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (long_hold_due && !long_hold_done) begin
      long_hold_done = 1'b1;
      stall_left = 79;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Predict on every accepted item, check every accepted result.
  always @(posedge clk_i) begin
    class_t want;
    class_t got;
    pixel_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_we_i) model_fs <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        class_q.push_back(nearest_colour(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                         s_axis_tdata[47:32], model_fs));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (class_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = class_q.pop_front();
          check_field("red_scaled", want.red, got.red);
          check_field("green_scaled", want.green, got.green);
          check_field("blue_scaled", want.blue, got.blue);
          check_field("color_index", want.idx, got.idx);
          check_field("best_distance", want.best_dist, got.best_dist);
          check_field("padding", want.pad, got.pad);
        end
      end
    end
  end

  task automatic add_pixel(input logic [15:0] r, g, b);
    pixel_q.push_back({b, g, r});
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || s_axis_tvalid || class_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_full_scale(input logic [15:0] fs);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= fs;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mix of raw noise, counts up to fs + fs/8 and counts that land near a reference colour.
  task automatic queue_random(input logic [15:0] fs, input int unsigned count);
    logic [15:0] ch [3];
    int          t;
    int unsigned raw;
    int unsigned k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, NumColours - 1);
      case ($urandom_range(0, 3))
        0: begin
          for (int c = 0; c < 3; c++) ch[c] = 16'($urandom());
        end
        1: begin
          for (int c = 0; c < 3; c++)
            ch[c] = 16'($urandom_range(0, (fs + fs / 8 > 65535) ? 65535 : fs + fs / 8));
        end
        default: begin
          for (int c = 0; c < 3; c++) begin
            t = int'(RefColour[k][c]) + int'($urandom_range(0, 16)) - 8;
            if (t < 0) t = 0;
            if (t > 255) t = 255;
            raw = (unsigned'(t) * fs) / 255 + $urandom_range(0, fs / 255);
            ch[c] = (raw > 65535) ? 16'hFFFF : 16'(raw);
          end
        end
      endcase
      add_pixel(ch[0], ch[1], ch[2]);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_full_scale(16'hFFFF);
    add_pixel(16'h0000, 16'h0000, 16'h0000);
    add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
    // each reference colour hit exactly: 257 * 255 = 65535
    for (int k = 0; k < NumColours; k++)
      add_pixel(16'(RefColour[k][0] * 257), 16'(RefColour[k][1] * 257),
                16'(RefColour[k][2] * 257));
    // equal distance to the second and fifth references: the earlier one wins
    add_pixel(16'(92 * 257), 16'(19 * 257), 16'(7 * 257));
    queue_random(16'hFFFF, 300);

    write_full_scale(16'd1024);
    add_pixel(16'd1024, 16'd1023, 16'd1025);
    add_pixel(16'hFFFF, 16'd0, 16'd4);
    queue_random(16'd1024, 200);

    // zero full scale: every channel scales to zero
    write_full_scale(16'd0);
    add_pixel(16'hFFFF, 16'h1234, 16'h0000);
    queue_random(16'd0, 30);

    write_full_scale(16'd1);
    add_pixel(16'h0000, 16'h0001, 16'hFFFF);
    queue_random(16'd1, 40);

    write_full_scale(16'd40000);
    queue_random(16'd40000, 250);
    long_hold_due = 1'b1;

    write_full_scale(16'($urandom_range(1024, 65535)));
    queue_random(model_fs, 150);

    write_full_scale(16'd255);
    queue_random(16'd255, 80);

    write_full_scale(16'hFFFF);
    calm = 1'b1;
    queue_random(16'hFFFF, 100);

    drain();
    if (mismatches == 0 && class_q.size() == 0) begin
      $display("nearest_reference_color_classifier test passed");
    end else begin
      $display("nearest_reference_color_classifier test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("nearest_reference_color_classifier test failed");
    $finish;
  end

endmodule

### files.f
sv/nrcc_pkg.sv
sv/nrcc_div_cell.sv
sv/nrcc_dist_cell.sv
sv/nearest_reference_color_classifier.sv
tb/sv/nearest_reference_color_classifier_test.sv
